### hw/rtl/i2cmbe_pkg.sv
// shared types and constants for the i2c master byte engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package i2cmbe_pkg;

  localparam int DATA_BITS_DEF = 8;
  localparam int PHASE_W       = 8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
  } status_t;

endpackage

### hw/rtl/i2cmbe_in_reg.sv
// input register stage of the i2c master byte engine
// depends on i2cmbe_pkg
`timescale 1ns / 1ps

module i2cmbe_in_reg
  import i2cmbe_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           func,
  input  logic [DATA_BITS-1:0] byte_in,
  input  logic                 ack_after_read,
  input  logic                 sda_in,
  input  logic                 take,
  output logic                 held_valid,
  output logic [2:0]           held_func,
  output logic [DATA_BITS-1:0] held_byte,
  output logic                 held_ack,
  output logic                 held_sda
);

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_func <= func;
      held_byte <= byte_in;
      held_ack  <= ack_after_read;
      held_sda  <= sda_in;
    end
  end

endmodule

### hw/rtl/i2cmbe_seq.sv
// phase sequencer of the i2c master byte engine: bus state and one tick of logic
// depends on i2cmbe_pkg
`timescale 1ns / 1ps

module i2cmbe_seq
  import i2cmbe_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [PHASE_W-1:0]   cfg_wr_data,
  input  logic                 step_en,
  input  logic [2:0]           func,
  input  logic [DATA_BITS-1:0] byte_in,
  input  logic                 ack_after_read,
  input  logic                 sda_in,
  output status_t              status_next,
  output logic [DATA_BITS-1:0] read_byte_next
);

  localparam int SEQ_LEN = DATA_BITS * 4 + 4;
  localparam int STEP_W  = $clog2(SEQ_LEN + 1);
  localparam logic [STEP_W-1:0] LEN_START = STEP_W'(2);
  localparam logic [STEP_W-1:0] LEN_STOP  = STEP_W'(3);
  localparam logic [STEP_W-1:0] LEN_BYTE  = STEP_W'(SEQ_LEN);
  localparam logic [STEP_W-3:0] ACK_BIT   = (STEP_W-2)'(DATA_BITS);

  typedef struct packed {
    logic [DATA_BITS-1:0] sr;
    logic                 scl;
    logic                 sda;
  } phase_t;

  logic [PHASE_W-1:0]   phase_ticks;
  cmd_t                 cmd, cmd_next;
  logic [PHASE_W-1:0]   timer, timer_next;
  logic [STEP_W-1:0]    step, step_next;
  logic                 ack, ack_next;
  phase_t               bus, bus_next;
  logic [DATA_BITS-1:0] read_result, read_result_next;
  logic                 done;
  logic [PHASE_W-1:0]   plen;
  logic [PHASE_W-1:0]   timer_inc;
  logic [STEP_W-1:0]    step_inc;
  logic [STEP_W-1:0]    seq_len;
  phase_t               start_bus;

  function automatic phase_t do_phase(cmd_t c, logic [STEP_W-1:0] s, phase_t cur,
                                      logic a, logic d);
    phase_t             r;
    logic               ackbit;
    logic [1:0]         q;
    r      = cur;
    q      = s[1:0];
    ackbit = s[STEP_W-1:2] >= ACK_BIT;
    case (c)
      CMD_START: begin
        if (s == '0) r.sda = 1'b0;
        else         r.scl = 1'b0;
      end
      CMD_STOP: begin
        if (s == '0)                  r.sda = 1'b0;
        else if (s == STEP_W'(1))     r.scl = 1'b1;
        else                          r.sda = 1'b1;
      end
      default: begin
        case (q)
          2'd0: begin
            if (c == CMD_WRITE) begin
              r.sda = ackbit ? 1'b1 : cur.sr[DATA_BITS-1];
            end else if (ackbit) begin
              r.sda = !a;
            end else begin
              r.sda = 1'b1;
              r.sr  = {cur.sr[DATA_BITS-2:0], 1'b0};
            end
          end
          2'd1: r.scl = 1'b1;
          2'd2: begin
            if (c == CMD_READ && !ackbit) r.sr = {cur.sr[DATA_BITS-1:1], d};
          end
          default: begin
            r.scl = 1'b0;
            if (c == CMD_WRITE && !ackbit) r.sr = {cur.sr[DATA_BITS-2:0], 1'b0};
          end
        endcase
      end
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_W'(1);
    end else if (cfg_wr_en) begin
      phase_ticks <= cfg_wr_data;
    end
  end

  // zero phase length behaves as one
  assign plen      = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
  assign timer_inc = timer + PHASE_W'(1);
  assign step_inc  = step + STEP_W'(1);

  always_comb begin
    unique case (cmd)
      CMD_START: seq_len = LEN_START;
      CMD_STOP:  seq_len = LEN_STOP;
      default:   seq_len = LEN_BYTE;
    endcase
  end

  always_comb begin
    start_bus     = bus;
    start_bus.sr  = (func == CMD_WRITE) ? byte_in : '0;

    cmd_next         = cmd;
    timer_next       = timer;
    step_next        = step;
    ack_next         = ack;
    bus_next         = bus;
    read_result_next = read_result;
    done             = 1'b0;

    if (cmd == CMD_NONE) begin
      // commands 5 to 7 are treated as no command
      if (func >= CMD_START && func <= CMD_READ) begin
        cmd_next   = cmd_t'(func);
        timer_next = '0;
        step_next  = '0;
        ack_next   = ack_after_read;
        bus_next   = do_phase(cmd_t'(func), '0, start_bus, ack_after_read, sda_in);
      end
    end else if (timer_inc >= plen) begin
      timer_next = '0;
      if (step_inc >= seq_len) begin
        if (cmd == CMD_READ) read_result_next = bus.sr;
        cmd_next  = CMD_NONE;
        step_next = '0;
        done      = 1'b1;
      end else begin
        step_next = step_inc;
        bus_next  = do_phase(cmd, step_inc, bus, ack, sda_in);
      end
    end else begin
      timer_next = timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd         <= CMD_NONE;
      timer       <= '0;
      step        <= '0;
      ack         <= 1'b0;
      bus.sr      <= '0;
      bus.scl     <= 1'b1;
      bus.sda     <= 1'b1;
      read_result <= '0;
    end else if (step_en) begin
      cmd         <= cmd_next;
      timer       <= timer_next;
      step        <= step_next;
      ack         <= ack_next;
      bus         <= bus_next;
      read_result <= read_result_next;
    end
  end

  assign status_next.scl  = bus_next.scl;
  assign status_next.sda  = bus_next.sda;
  assign status_next.busy = cmd_next != CMD_NONE;
  assign status_next.done = done;
  assign read_byte_next   = read_result_next;

endmodule

### hw/rtl/i2cmbe_out_reg.sv
// result register of the i2c master byte engine
// depends on i2cmbe_pkg
`timescale 1ns / 1ps

module i2cmbe_out_reg
  import i2cmbe_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  status_t              status_next,
  input  logic [DATA_BITS-1:0] read_byte_next,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_level,
  output logic                 sda_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [DATA_BITS-1:0] read_byte
);

  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status    <= status_next;
      read_byte <= read_byte_next;
    end
  end

  assign scl_level = status.scl;
  assign sda_level = status.sda;
  assign busy_res  = status.busy;
  assign done_res  = status.done;

endmodule

### hw/rtl/i2c_master_byte_engine_core.sv
// i2c master byte engine: an accepted tick request passes through the input register,
// then one pass of sequencer logic into the result register
// throughput one request per cycle, one result per request; the input stage stalls
// only while a result is held back by out_stall
// synchronous active-high reset: bus lines released, engine idle, phase length 1
// depends on i2cmbe_pkg, i2cmbe_in_reg, i2cmbe_seq, i2cmbe_out_reg
`timescale 1ns / 1ps

module i2c_master_byte_engine_core
  import i2cmbe_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: ticks per quarter-bit phase
  input  logic                 cfg_wr_en,
  input  logic [PHASE_W-1:0]   cfg_wr_data,
  // tick request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           func,
  input  logic [DATA_BITS-1:0] byte_in,
  input  logic                 ack_after_read,
  input  logic                 sda_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_level,
  output logic                 sda_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [DATA_BITS-1:0] read_byte
);

  // held request from the input stage
  logic                 held_valid;
  logic [2:0]           held_func;
  logic [DATA_BITS-1:0] held_byte;
  logic                 held_ack;
  logic                 held_sda;

  // next result from the sequencer
  status_t              status_next;
  logic [DATA_BITS-1:0] read_byte_next;

  // a held request advances when the result slot is free or being emptied;
  // the sequencer state steps on exactly those cycles
  logic                 advance;

  assign advance = held_valid && (!out_valid || !out_stall);

  i2cmbe_in_reg #(
    .DATA_BITS(DATA_BITS)
  ) u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .byte_in       (byte_in),
    .ack_after_read(ack_after_read),
    .sda_in        (sda_in),
    .take          (advance),
    .held_valid    (held_valid),
    .held_func     (held_func),
    .held_byte     (held_byte),
    .held_ack      (held_ack),
    .held_sda      (held_sda)
  );

  // one tick of bus sequencing: start, stop, write byte or read byte phases
  i2cmbe_seq #(
    .DATA_BITS(DATA_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .step_en       (advance),
    .func          (held_func),
    .byte_in       (held_byte),
    .ack_after_read(held_ack),
    .sda_in        (held_sda),
    .status_next   (status_next),
    .read_byte_next(read_byte_next)
  );

  // result register parts the sequencer from the downstream stall
  i2cmbe_out_reg #(
    .DATA_BITS(DATA_BITS)
  ) u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .status_next   (status_next),
    .read_byte_next(read_byte_next),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_level     (scl_level),
    .sda_level     (sda_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_byte     (read_byte)
  );

endmodule

### hw/rtl/i2cmbe_checker.sv
// port-level checks for the i2c master byte engine, bound to the top level
// depends on i2cmbe_pkg and i2c_master_byte_engine_core
`timescale 1ns / 1ps

module i2cmbe_checker
  import i2cmbe_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 scl_level,
  input logic                 sda_level,
  input logic                 busy_res,
  input logic                 done_res,
  input logic [DATA_BITS-1:0] read_byte
);

  // a finished sequence is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done_res with busy_res");

  // an empty result slot always lets the input stage drain
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(busy_res) && $stable(done_res) && $stable(read_byte))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_core i2cmbe_checker #(
  .DATA_BITS(DATA_BITS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .scl_level(scl_level),
  .sda_level(sda_level),
  .busy_res (busy_res),
  .done_res (done_res),
  .read_byte(read_byte)
);
